/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/ssgc_pkg.sv */
// Shared constants and command type of the scaled sign gradient compressor.
`timescale 1ns / 1ps
package ssgc_pkg;
	localparam int PACK_W       = 32;
	localparam int BITS_W       = 5;
	localparam int CNT_W        = 21;
	localparam int SUM_W        = 52;
	localparam int MAX_ELEMENTS = 1048576;
	localparam logic [PACK_W-1:0] SCALE_ONE = 32'h0001_0000;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = 2;
	localparam int DIV_STEPS    = 52;
	localparam int DIVC_W       = 6;

	typedef struct packed {
		logic              has_word;
		logic [PACK_W-1:0] word;
		logic              has_scale;
		logic              scale_en;
		logic [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]  count;
	} cmd_t;
endpackage

/* rtl/ssgc_front.sv */
// Front end: accepts gradients, packs sign bits, accumulates magnitudes, issues commands.
`timescale 1ns / 1ps
module ssgc_front import ssgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_data
);
	logic              scaling_q;
	logic [PACK_W-1:0] shift_q;
	logic [BITS_W-1:0] bits_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;

	logic              accept;
	logic              positive;
	logic [31:0]       magnitude;
	logic              saturated;
	logic [CNT_W-1:0]  count_n;
	logic [SUM_W-1:0]  sum_n;
	logic [PACK_W-1:0] shift_n;
	logic [BITS_W-1:0] bits_n;
	logic              word_full;
	logic [BITS_W:0]   pad_sh;

	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign positive  = !s_tdata[31] && (s_tdata != 32'd0);
	assign magnitude = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
	assign saturated = (count_q == CNT_W'(MAX_ELEMENTS));
	assign count_n   = saturated ? count_q : count_q + CNT_W'(1);
	assign sum_n     = saturated ? sum_q : sum_q + SUM_W'(magnitude);
	assign shift_n   = {shift_q[PACK_W-2:0], positive};
	assign bits_n    = bits_q + BITS_W'(1);
	assign word_full = (bits_q == BITS_W'(PACK_W - 1));
	assign pad_sh    = (BITS_W+1)'(PACK_W) - {1'b0, bits_n};

	assign push = accept && (word_full || s_tlast);

	always_comb begin
		push_data.has_word  = 1'b1;
		push_data.word      = word_full ? shift_n : (shift_n << pad_sh);
		push_data.has_scale = s_tlast;
		push_data.scale_en  = scaling_q;
		push_data.sum       = sum_n;
		push_data.count     = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scaling_q <= 1'b1;
			shift_q   <= '0;
			bits_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				scaling_q <= cfg_wr_data;
			end
			if (accept) begin
				if (s_tlast) begin
					shift_q <= '0;
					bits_q  <= '0;
					count_q <= '0;
					sum_q   <= '0;
				end else begin
					shift_q <= word_full ? '0 : shift_n;
					bits_q  <= word_full ? '0 : bits_n;
					count_q <= count_n;
					sum_q   <= sum_n;
				end
			end
		end
	end
endmodule

/* rtl/ssgc_queue.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module ssgc_queue import ssgc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t pop_data,
	output logic full,
	output logic empty
);
	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end
endmodule

/* rtl/ssgc_back.sv */
// Back end: emits sign words, divides the magnitude sum, emits the scale word.
`timescale 1ns / 1ps
module ssgc_back import ssgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_data,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WORD  = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_SCALE = 4'b1000
	} bst_t;

	bst_t              st_q;
	cmd_t              cmd_q;
	logic [SUM_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DIVC_W-1:0] step_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic              out_user_q;
	logic              out_last_q;

	logic              slot_free;
	logic              load_word;
	logic              load_scale;
	logic              div_step;
	logic              run_div_in;
	logic              run_div;
	logic [CNT_W:0]    trial;
	logic              ge;
	logic [CNT_W:0]    diff;

	assign slot_free  = !out_valid_q || m_tready;
	assign pop        = (st_q == ST_IDLE) && !q_empty;
	assign load_word  = (st_q == ST_WORD) && slot_free;
	assign load_scale = (st_q == ST_SCALE) && slot_free;
	assign div_step   = (st_q == ST_DIV);
	assign run_div_in = q_data.scale_en && (q_data.count != '0);
	assign run_div    = cmd_q.scale_en && (cmd_q.count != '0);

	assign trial = {rem_q, div_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, cmd_q.count});
	assign diff  = trial - {1'b0, cmd_q.count};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_data;
			div_q <= q_data.sum;
			rem_q <= '0;
		end else if (div_step) begin
			div_q <= {div_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
		if (load_word) begin
			out_data_q <= cmd_q.word;
			out_user_q <= 1'b0;
			out_last_q <= 1'b0;
		end else if (load_scale) begin
			out_data_q <= run_div ? div_q[31:0] : SCALE_ONE;
			out_user_q <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_word || load_scale) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!q_empty) begin
						if (q_data.has_word) begin
							st_q <= ST_WORD;
						end else begin
							st_q <= run_div_in ? ST_DIV : ST_SCALE;
						end
					end
				end
				ST_WORD: begin
					if (slot_free) begin
						if (cmd_q.has_scale) begin
							st_q <= run_div ? ST_DIV : ST_SCALE;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + DIVC_W'(1);
					if (step_q == DIVC_W'(DIV_STEPS - 1)) begin
						st_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (slot_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* rtl/scaled_sign_gradient_compressor.sv */
// Top level of the scaled sign gradient compressor.
// Input stream: s_tdata carries one signed Q16.16 gradient, s_tlast marks the
// last element of a tensor. Output stream: m_tdata carries a packed sign word
// (first element in the MSB) or the unsigned Q16.16 scale, m_tuser is 1 on the
// scale, m_tlast is 1 on the scale that closes the tensor.
// cfg_wr_en/cfg_wr_data write the scaling enable (reset 1); write it only while
// the block is idle. Scale is the truncated mean |gradient| or 1.0.
// Throughput: one gradient per cycle while the command queue has room; only
// every 32nd element and each tensor end place a request in the 4-deep queue.
// Path: a sign word passes through the queue, the command register and the
// output register; the scale also waits for the one-bit-per-cycle restoring
// divider when scaling is on and the element count is nonzero.
// Reset clears all packing state and empties the queue and output register.
// When the receiver stalls, the output register holds, the back end waits,
// and s_tready drops once the queue is full.
`timescale 1ns / 1ps
module scaled_sign_gradient_compressor import ssgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] gradient
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] payload
	output logic        m_tuser,   // [0] is_scale
	output logic        m_tlast
);
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cmd_t push_data;
	cmd_t pop_data;

	ssgc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	ssgc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	ssgc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);
endmodule

/* rtl/ssgc_checker.sv */
// Port-level checker for the scaled sign gradient compressor, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssgc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic        cfg_wr_data,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	logic scl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q <= 1'b1;
		end else if (cfg_wr_en) begin
			scl_q <= cfg_wr_data;
		end
	end

	`ASSERT_ALWAYS(a_last_is_scale, m_tvalid |-> (m_tlast == m_tuser))
	`ASSERT_ALWAYS(a_fixed_scale, (m_tvalid && m_tuser && !scl_q) |-> (m_tdata == 32'h0001_0000))
	`ASSERT_ALWAYS(a_mean_range, (m_tvalid && m_tuser && scl_q) |-> (m_tdata <= 32'h8000_0000))
	`ASSERT_NEXT(a_out_hold, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata)))
endmodule

bind scaled_sign_gradient_compressor ssgc_checker u_chk (.*);

/* tb/sv/scaled_sign_gradient_compressor_tb.sv */
// Self-checking testbench of the scaled sign gradient compressor stream block.
`timescale 1ns / 1ps
module scaled_sign_gradient_compressor_tb;
	import ssgc_pkg::*;

	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 650;

	typedef struct packed {
		logic [PACK_W-1:0] payload;
		logic              is_scale;
		logic              final_item;
	} packed_result_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata     = '0;
	logic        s_tlast     = 1'b0;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	packed_result_t    pending_results[$];
	packed_result_t    oldest_result;
	logic [PACK_W-1:0] sign_word;
	int                sign_bits;
	int                tensor_count;
	logic [SUM_W-1:0]  tensor_abs_sum;
	logic              scale_enable;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                mismatches;
	int                quiet_cycles;

	scaled_sign_gradient_compressor u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: payload %h is_scale %b final_item %b",
					m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (m_tdata !== oldest_result.payload) begin
					$error("payload: expected %h, got %h", oldest_result.payload, m_tdata);
					mismatches++;
				end
				if (m_tuser !== oldest_result.is_scale) begin
					$error("is_scale: expected %b, got %b", oldest_result.is_scale, m_tuser);
					mismatches++;
				end
				if (m_tlast !== oldest_result.final_item) begin
					$error("final_item: expected %b, got %b", oldest_result.final_item, m_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic clear_tensor();
		sign_word      = '0;
		sign_bits      = 0;
		tensor_count   = 0;
		tensor_abs_sum = '0;
	endtask

	task automatic pack_gradient(input logic [31:0] gradient, input logic last);
		logic [31:0]       magnitude;
		logic [PACK_W-1:0] scale;
		magnitude = gradient[31] ? (~gradient + 32'd1) : gradient;
		if (tensor_count < MAX_ELEMENTS) begin
			tensor_count++;
			tensor_abs_sum = tensor_abs_sum + SUM_W'(magnitude);
		end
		sign_word = {sign_word[PACK_W-2:0], (!gradient[31] && gradient != 32'd0)};
		sign_bits++;
		if (sign_bits == PACK_W) begin
			pending_results.push_back('{sign_word, 1'b0, 1'b0});
			sign_word = '0;
			sign_bits = 0;
		end
		if (last) begin
			if (sign_bits != 0)
				pending_results.push_back('{sign_word << (PACK_W - sign_bits), 1'b0, 1'b0});
			scale = SCALE_ONE;
			if (scale_enable && tensor_count != 0)
				scale = PACK_W'(tensor_abs_sum / SUM_W'(tensor_count));
			pending_results.push_back('{scale, 1'b1, 1'b1});
			clear_tensor();
		end
	endtask

	task automatic send_gradient(input logic [31:0] gradient, input logic last);
		logic accepted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= gradient;
		s_tlast  <= last;
		do begin
			@(negedge clk);
			accepted = s_tready;
			@(posedge clk);
		end while (!accepted);
		pack_gradient(gradient, last);
	endtask

	function automatic logic [31:0] random_gradient();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'($urandom_range(1, 65535));
			4:       return -32'($urandom_range(1, 65535));
			default: return $urandom;
		endcase
	endfunction

	function automatic int random_tensor_length();
		case ($urandom_range(9))
			0:       return 1;
			1, 2:    return 32 * $urandom_range(1, 3);
			3:       return 32 * $urandom_range(1, 3) + ($urandom_range(1) ? 1 : -1);
			4, 5, 6: return $urandom_range(2, 40);
			default: return $urandom_range(41, 150);
		endcase
	endfunction

	task automatic send_random_tensor(input int length);
		for (int i = 0; i < length; i++)
			send_gradient(random_gradient(), i == length - 1);
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_scaling(input logic enable);
		settle_block();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= enable;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		scale_enable = enable;
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		int sent;
		int length;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			length = random_tensor_length();
			send_random_tensor(length);
			sent += length;
		end
	endtask

	task automatic test_directed_extremes();
		send_gradient(32'h7FFF_FFFF, 1'b1);
		send_gradient(32'h8000_0000, 1'b1);
		send_gradient(32'h0000_0000, 1'b1);
		send_gradient(32'h0000_0001, 1'b0);
		send_gradient(32'hFFFF_FFFF, 1'b0);
		send_gradient(32'h0000_0000, 1'b0);
		send_gradient(32'h7FFF_FFFF, 1'b0);
		send_gradient(32'h8000_0000, 1'b0);
		send_gradient(32'h0001_0000, 1'b0);
		send_gradient(32'hFFFF_0000, 1'b0);
		send_gradient(32'h0000_0001, 1'b1);
	endtask

	task automatic test_fixed_scale();
		set_scaling(1'b0);
		send_gradient(32'hDEAD_BEEF, 1'b0);
		send_gradient(32'h1234_5678, 1'b1);
		set_scaling(1'b1);
	endtask

	task automatic test_random_traffic();
		run_random_phase(12, 49);
		set_scaling(1'b0);
		run_random_phase(49, 12);
		set_scaling(1'b1);
		run_random_phase(0, 0);
	endtask

	initial begin
		scale_enable  = 1'b1;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		mismatches    = 0;
		quiet_cycles  = 0;
		clear_tensor();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_fixed_scale();
		test_random_traffic();

		settle_block();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

/* scaled_sign_gradient_compressor.f */
+incdir+rtl
rtl/ssgc_pkg.sv
rtl/ssgc_front.sv
rtl/ssgc_queue.sv
rtl/ssgc_back.sv
rtl/scaled_sign_gradient_compressor.sv
rtl/ssgc_checker.sv
tb/sv/scaled_sign_gradient_compressor_tb.sv
